/* rtl/circular_byte_fifo_burst_macros.svh */
// Assertion macros shared by the FIFO RTL.
`ifndef CIRCULAR_BYTE_FIFO_BURST_MACROS_SVH
`define CIRCULAR_BYTE_FIFO_BURST_MACROS_SVH

// Checked only outside reset.
`define CBF_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CBF_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cbf_pkg.sv */
// Shared types and constants of the byte ring FIFO.
package cbf_pkg;

    localparam int BURST_LANES = 8;
    localparam int LANE_W      = 3;
    localparam int CNT_W       = 4;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_PEEK   = 2'd2;
    localparam logic [1:0] CMD_STATUS = 2'd3;

    typedef logic [7:0] byte_t;

    // One burst over the lanes: start lane and length.
    typedef struct packed {
        logic              go;
        logic [LANE_W-1:0] base;
        logic [CNT_W-1:0]  count;
    } burst_t;

    typedef struct packed {
        burst_t wr;
        burst_t rd;
    } lane_ctrl_t;

endpackage

/* rtl/cbf_lane.sv */
// One storage lane: a bank holding every eighth byte of the ring.
module cbf_lane #(
    parameter int LANE_ID = 0,
    parameter int ROWS    = 2,
    localparam int ROW_W  = $clog2(ROWS)
) (
    input  logic                clk,
    input  cbf_pkg::lane_ctrl_t ctrl,
    input  logic [ROW_W-1:0]    wr_row,
    input  logic [ROW_W-1:0]    wr_row_inc,
    input  logic [ROW_W-1:0]    rd_row,
    input  logic [ROW_W-1:0]    rd_row_inc,
    input  cbf_pkg::byte_t      push_data [cbf_pkg::BURST_LANES],
    output cbf_pkg::byte_t      rd_data
);

    localparam logic [cbf_pkg::LANE_W-1:0] ID = cbf_pkg::LANE_W'(LANE_ID);

    cbf_pkg::byte_t mem_reg [ROWS];
    cbf_pkg::byte_t rd_data_reg;

    logic [cbf_pkg::LANE_W-1:0] wr_off;
    logic [cbf_pkg::LANE_W-1:0] rd_off;
    logic                       wr_hit;
    logic                       rd_hit;
    logic [ROW_W-1:0]           wr_row_sel;
    logic [ROW_W-1:0]           rd_row_sel;

    // position of this lane inside the burst; lanes before the base sit one row on
    assign wr_off     = ID - ctrl.wr.base;
    assign rd_off     = ID - ctrl.rd.base;
    assign wr_hit     = ctrl.wr.go && (cbf_pkg::CNT_W'(wr_off) < ctrl.wr.count);
    assign rd_hit     = ctrl.rd.go && (cbf_pkg::CNT_W'(rd_off) < ctrl.rd.count);
    assign wr_row_sel = (ID >= ctrl.wr.base) ? wr_row : wr_row_inc;
    assign rd_row_sel = (ID >= ctrl.rd.base) ? rd_row : rd_row_inc;

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem_reg[wr_row_sel] <= push_data[wr_off];
        end
        if (rd_hit)
        begin
            rd_data_reg <= mem_reg[rd_row_sel];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/cbf_merge.sv */
// Merge stage: rotates lane read data into burst order and zeroes unused bytes.
module cbf_merge (
    input  cbf_pkg::burst_t rd,
    input  cbf_pkg::byte_t  lane_data  [cbf_pkg::BURST_LANES],
    output cbf_pkg::byte_t  read_bytes [cbf_pkg::BURST_LANES]
);

    always_comb
    begin
        for (int i = 0; i < cbf_pkg::BURST_LANES; i++)
        begin
            if (rd.go && (cbf_pkg::CNT_W'(i) < rd.count))
            begin
                read_bytes[i] = lane_data[cbf_pkg::LANE_W'(rd.base + cbf_pkg::LANE_W'(i))];
            end
            else
            begin
                read_bytes[i] = '0;
            end
        end
    end

endmodule

/* rtl/circular_byte_fifo_burst.sv */
// Top level of the burst byte ring FIFO.
// Byte ring FIFO taking one request per clock while out_stall is low: push,
// pop, peek or status, each moving 0 to 8 bytes all-or-nothing. A request is
// accepted on the input channel, held in stage 1, then shown on the output
// channel; this rate is sustained, set by the registered read of the lane banks
// feeding a result register. The ring is split over eight lane banks, byte k
// of the stream in bank k mod 8, so a burst touches each bank at most once.
// Occupancy is kept as a counter; the ring length written over the config
// port (clamped to 2..MAX_DEPTH) sets the capacity, which is length minus one.
// A length write empties the FIFO and must be made while no request is in
// flight. Storage needs no clearing pass after reset.
module circular_byte_fifo_burst #(
    parameter int MAX_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    // ring length register
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [3:0] burst_count,
    input  logic [7:0] push_byte_0,
    input  logic [7:0] push_byte_1,
    input  logic [7:0] push_byte_2,
    input  logic [7:0] push_byte_3,
    input  logic [7:0] push_byte_4,
    input  logic [7:0] push_byte_5,
    input  logic [7:0] push_byte_6,
    input  logic [7:0] push_byte_7,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted,
    output logic [7:0] read_byte_0,
    output logic [7:0] read_byte_1,
    output logic [7:0] read_byte_2,
    output logic [7:0] read_byte_3,
    output logic [7:0] read_byte_4,
    output logic [7:0] read_byte_5,
    output logic [7:0] read_byte_6,
    output logic [7:0] read_byte_7,
    output logic [7:0] free_space,
    output logic [7:0] occupancy,
    output logic       empty_flag
);

`include "circular_byte_fifo_burst_macros.svh"

    localparam int LANES     = cbf_pkg::BURST_LANES;
    localparam int LW        = cbf_pkg::LANE_W;
    localparam int LEN_W     = $clog2(MAX_DEPTH + 1);
    localparam int ROWS_RAW  = (MAX_DEPTH + LANES - 1) / LANES;
    localparam int ROWS      = (ROWS_RAW < 2) ? 2 : ROWS_RAW;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int PHYS      = ROWS * LANES;
    localparam int PHYS_W    = ROW_W + LW;
    localparam int RESET_LEN = (MAX_DEPTH < 256) ? MAX_DEPTH : 256;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  occ_reg;
    logic [PHYS_W-1:0] wphys_reg;
    logic [PHYS_W-1:0] rphys_reg;

    // stage 1: request done, bank reads in flight
    logic              s1_valid_reg;
    logic              s1_acc_reg;
    cbf_pkg::burst_t   s1_rd_reg;
    logic [7:0]        s1_free_reg;
    logic [7:0]        s1_occ_reg;
    logic              s1_empty_reg;

    // result register
    logic              out_valid_reg;
    logic              acc_out_reg;
    cbf_pkg::byte_t    rbyte_reg [LANES];
    logic [7:0]        free_out_reg;
    logic [7:0]        occ_out_reg;
    logic              empty_out_reg;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    logic cfg_take;
    logic in_take;
    logic s1_move;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_take   = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // Ring length clamp
    // ---------------------------------------------------------------
    logic [LEN_W-1:0] len_clamped;

    always_comb
    begin
        if (32'(cfg_data) > MAX_DEPTH)
        begin
            len_clamped = LEN_W'(MAX_DEPTH);
        end
        else if (cfg_data < 9'd2)
        begin
            len_clamped = LEN_W'(2);
        end
        else
        begin
            len_clamped = LEN_W'(cfg_data);
        end
    end

    // ---------------------------------------------------------------
    // Request decision
    // ---------------------------------------------------------------
    logic [LEN_W-1:0] room_now;
    logic             cnt_ok;
    logic             is_push;
    logic             is_read;
    logic             acc_now;
    logic [LEN_W-1:0] occ_after;
    logic [LEN_W-1:0] free_after;

    assign room_now = len_reg - LEN_W'(1) - occ_reg;
    assign cnt_ok   = (burst_count <= cbf_pkg::CNT_W'(LANES));

    always_comb
    begin
        is_push = 1'b0;
        is_read = 1'b0;
        acc_now = 1'b1;
        unique case (command) inside
            cbf_pkg::CMD_PUSH:
            begin
                is_push = 1'b1;
                acc_now = cnt_ok && (32'(burst_count) <= 32'(room_now));
            end
            cbf_pkg::CMD_POP, cbf_pkg::CMD_PEEK:
            begin
                is_read = 1'b1;
                acc_now = cnt_ok && (32'(burst_count) <= 32'(occ_reg));
            end
            cbf_pkg::CMD_STATUS:
            begin
                acc_now = 1'b1;
            end
        endcase
    end

    // occupancy as it stands once this request is carried out
    always_comb
    begin
        occ_after = occ_reg;
        if (acc_now && is_push)
        begin
            occ_after = occ_reg + LEN_W'(burst_count);
        end
        else if (acc_now && (command == cbf_pkg::CMD_POP))
        begin
            occ_after = occ_reg - LEN_W'(burst_count);
        end
    end

    assign free_after = len_reg - LEN_W'(1) - occ_after;

    // ---------------------------------------------------------------
    // Bank pointers: wrap at the bank ring size, not the ring length
    // ---------------------------------------------------------------
    logic [PHYS_W:0]   wsum;
    logic [PHYS_W:0]   rsum;
    logic [PHYS_W-1:0] wphys_adv;
    logic [PHYS_W-1:0] rphys_adv;
    logic [ROW_W-1:0]  wrow;
    logic [ROW_W-1:0]  rrow;
    logic [ROW_W-1:0]  wrow_inc;
    logic [ROW_W-1:0]  rrow_inc;

    assign wsum      = {1'b0, wphys_reg} + (PHYS_W + 1)'(burst_count);
    assign rsum      = {1'b0, rphys_reg} + (PHYS_W + 1)'(burst_count);
    assign wphys_adv = (wsum >= (PHYS_W + 1)'(PHYS)) ?
                       PHYS_W'(wsum - (PHYS_W + 1)'(PHYS)) : PHYS_W'(wsum);
    assign rphys_adv = (rsum >= (PHYS_W + 1)'(PHYS)) ?
                       PHYS_W'(rsum - (PHYS_W + 1)'(PHYS)) : PHYS_W'(rsum);
    assign wrow      = wphys_reg[PHYS_W-1:LW];
    assign rrow      = rphys_reg[PHYS_W-1:LW];
    assign wrow_inc  = (wrow == ROW_W'(ROWS - 1)) ? '0 : wrow + 1'b1;
    assign rrow_inc  = (rrow == ROW_W'(ROWS - 1)) ? '0 : rrow + 1'b1;

    // ---------------------------------------------------------------
    // Lanes
    // ---------------------------------------------------------------
    cbf_pkg::lane_ctrl_t lane_ctrl;
    cbf_pkg::byte_t      push_data [LANES];
    cbf_pkg::byte_t      lane_data [LANES];

    assign push_data[0] = push_byte_0;
    assign push_data[1] = push_byte_1;
    assign push_data[2] = push_byte_2;
    assign push_data[3] = push_byte_3;
    assign push_data[4] = push_byte_4;
    assign push_data[5] = push_byte_5;
    assign push_data[6] = push_byte_6;
    assign push_data[7] = push_byte_7;

    always_comb
    begin
        lane_ctrl.wr.go    = in_take && !cfg_take && acc_now && is_push;
        lane_ctrl.wr.base  = wphys_reg[LW-1:0];
        lane_ctrl.wr.count = burst_count;
        lane_ctrl.rd.go    = in_take && !cfg_take && acc_now && is_read;
        lane_ctrl.rd.base  = rphys_reg[LW-1:0];
        lane_ctrl.rd.count = burst_count;
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        cbf_lane #(
            .LANE_ID (g),
            .ROWS    (ROWS)
        ) u_lane (
            .clk        (clk),
            .ctrl       (lane_ctrl),
            .wr_row     (wrow),
            .wr_row_inc (wrow_inc),
            .rd_row     (rrow),
            .rd_row_inc (rrow_inc),
            .push_data  (push_data),
            .rd_data    (lane_data[g])
        );
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_W'(RESET_LEN);
            occ_reg   <= '0;
            wphys_reg <= '0;
            rphys_reg <= '0;
        end
        else if (cfg_take)
        begin
            // a new length empties the ring
            len_reg   <= len_clamped;
            occ_reg   <= '0;
            wphys_reg <= '0;
            rphys_reg <= '0;
        end
        else if (in_take && acc_now)
        begin
            occ_reg <= occ_after;
            if (is_push)
            begin
                wphys_reg <= wphys_adv;
            end
            if (command == cbf_pkg::CMD_POP)
            begin
                rphys_reg <= rphys_adv;
            end
        end
    end

    // stage 1 and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    cbf_pkg::byte_t read_bytes [LANES];

    cbf_merge u_merge (
        .rd         (s1_rd_reg),
        .lane_data  (lane_data),
        .read_bytes (read_bytes)
    );

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_acc_reg   <= acc_now;
            s1_rd_reg    <= lane_ctrl.rd;
            s1_free_reg  <= 8'(free_after);
            s1_occ_reg   <= 8'(occ_after);
            s1_empty_reg <= (occ_after == '0);
        end
        if (s1_move)
        begin
            acc_out_reg   <= s1_acc_reg;
            rbyte_reg     <= read_bytes;
            free_out_reg  <= s1_free_reg;
            occ_out_reg   <= s1_occ_reg;
            empty_out_reg <= s1_empty_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = acc_out_reg;
    assign read_byte_0 = rbyte_reg[0];
    assign read_byte_1 = rbyte_reg[1];
    assign read_byte_2 = rbyte_reg[2];
    assign read_byte_3 = rbyte_reg[3];
    assign read_byte_4 = rbyte_reg[4];
    assign read_byte_5 = rbyte_reg[5];
    assign read_byte_6 = rbyte_reg[6];
    assign read_byte_7 = rbyte_reg[7];
    assign free_space  = free_out_reg;
    assign occupancy   = occ_out_reg;
    assign empty_flag  = empty_out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic [PHYS_W-1:0] ptr_gap;

    // distance from read to write pointer around the bank ring
    assign ptr_gap = (wphys_reg >= rphys_reg) ? (wphys_reg - rphys_reg) :
                     PHYS_W'({1'b0, wphys_reg} + (PHYS_W + 1)'(PHYS) - {1'b0, rphys_reg});

    `CBF_ASSERT(a_occ_below_len, occ_reg < len_reg, "occupancy reached ring length")
    `CBF_ASSERT(a_gap_matches_occ, 32'(ptr_gap) == 32'(occ_reg), "bank pointer gap differs from occupancy")
    `CBF_ASSERT(a_refused_holds, in_take && !cfg_take && !acc_now |=> occ_reg == $past(occ_reg), "refused request moved occupancy")
    `CBF_ASSERT(a_cfg_clears, cfg_take |=> occ_reg == '0 && wphys_reg == rphys_reg, "length write did not empty ring")
    `CBF_ASSERT_ALWAYS(a_drain, out_valid_reg && !out_stall && !s1_valid_reg |=> !out_valid_reg, "result shown twice")

endmodule
